[hdl/entry_path_validator_assert.svh]
// Assertion macros shared by the entry path validator modules.
`ifndef ENTRY_PATH_VALIDATOR_ASSERT_SVH
`define ENTRY_PATH_VALIDATOR_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define EPV_ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed in %m");

// Consequence must hold in the same cycle as the antecedent.
`define EPV_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// Consequence must hold in the cycle after the antecedent.
`define EPV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

[hdl/epv_pkg.sv]
// Types, constants and per-byte update functions of the entry path validator.
package epv_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int DEPTH_BITS  = 8;

  localparam int COUNT_W   = LENGTH_BITS + 1;
  localparam int DEPTH_W   = DEPTH_BITS + 1;
  localparam int SEG_W     = 9;
  localparam int MAXLEN_W  = 16;
  localparam int MAXDEP_W  = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH  = 1'd1;

  localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RESET = 16'd4096;
  localparam logic [MAXDEP_W-1:0] MAX_DEPTH_RESET  = 8'd32;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNSAFE = 2'd1;
  localparam logic [1:0] ST_LIMIT  = 2'd2;

  // Reason codes
  localparam logic [3:0] RS_OK            = 4'd0;
  localparam logic [3:0] RS_EMPTY         = 4'd1;
  localparam logic [3:0] RS_TOO_LONG      = 4'd2;
  localparam logic [3:0] RS_FORBIDDEN     = 4'd3;
  localparam logic [3:0] RS_LEAD_SLASH    = 4'd4;
  localparam logic [3:0] RS_TRAIL_SLASH   = 4'd5;
  localparam logic [3:0] RS_BAD_UTF8      = 4'd6;
  localparam logic [3:0] RS_DOT_SEGMENT   = 4'd7;
  localparam logic [3:0] RS_EMPTY_SEGMENT = 4'd8;
  localparam logic [3:0] RS_TOO_DEEP      = 4'd9;

  // Segment error codes
  localparam logic [1:0] SEGERR_NONE  = 2'd0;
  localparam logic [1:0] SEGERR_DOT   = 2'd1;
  localparam logic [1:0] SEGERR_EMPTY = 2'd2;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CONT_LOW  = 8'h80;
  localparam logic [7:0] CONT_HIGH = 8'hBF;

  localparam logic [COUNT_W-1:0] COUNT_CAP   = {COUNT_W{1'b1}};
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = {1'b1, {DEPTH_BITS{1'b0}}};

  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic               last_was_slash;
    logic               forbidden_seen;
    logic               leading_slash_seen;
    logic               utf8_error;
    logic [1:0]         utf8_pending;
    logic               utf8_expect_first;
    logic [7:0]         first_cont_low;
    logic [7:0]         first_cont_high;
    logic [1:0]         segment_length;
    logic               segment_all_dots;
    logic [1:0]         segment_error;
    logic [DEPTH_W-1:0] depth_count;
  } epv_state_t;

  localparam epv_state_t STATE_CLEAR = '{
    byte_count:         '0,
    last_was_slash:     1'b0,
    forbidden_seen:     1'b0,
    leading_slash_seen: 1'b0,
    utf8_error:         1'b0,
    utf8_pending:       2'd0,
    utf8_expect_first:  1'b0,
    first_cont_low:     CONT_LOW,
    first_cont_high:    CONT_HIGH,
    segment_length:     2'd0,
    segment_all_dots:   1'b1,
    segment_error:      SEGERR_NONE,
    depth_count:        '0
  };

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       reason;
    logic [SEG_W-1:0] segment_count;
  } epv_result_t;

  // Latch the first bad segment, bump depth (saturating), open a new segment.
  function automatic epv_state_t close_segment(epv_state_t s);
    epv_state_t r;
    r = s;
    if (s.segment_error == SEGERR_NONE) begin
      if (s.segment_length == 2'd0) begin
        r.segment_error = SEGERR_EMPTY;
      end else if (s.segment_all_dots && s.segment_length <= 2'd2) begin
        r.segment_error = SEGERR_DOT;
      end
    end
    if (s.depth_count < DEPTH_LIMIT) begin
      r.depth_count = s.depth_count + DEPTH_W'(1);
    end
    r.segment_length   = 2'd0;
    r.segment_all_dots = 1'b1;
    return r;
  endfunction

  function automatic epv_state_t lead_byte(epv_state_t s, logic [1:0] need,
                                           logic [7:0] lo, logic [7:0] hi);
    epv_state_t r;
    r = s;
    r.utf8_pending      = need;
    r.utf8_expect_first = 1'b1;
    r.first_cont_low    = lo;
    r.first_cont_high   = hi;
    return r;
  endfunction

  // One step of the UTF-8 decoder; stop once an error is latched.
  function automatic epv_state_t utf8_feed(epv_state_t s, logic [7:0] b);
    epv_state_t r;
    logic [7:0] lo;
    logic [7:0] hi;
    r  = s;
    lo = s.utf8_expect_first ? s.first_cont_low : CONT_LOW;
    hi = s.utf8_expect_first ? s.first_cont_high : CONT_HIGH;
    if (!s.utf8_error) begin
      if (s.utf8_pending == 2'd0) begin
        if (b < 8'h80) begin
          r = s;
        end else if (b inside {[8'hC2:8'hDF]}) begin
          r = lead_byte(s, 2'd1, CONT_LOW, CONT_HIGH);
        end else if (b == 8'hE0) begin
          r = lead_byte(s, 2'd2, 8'hA0, CONT_HIGH);
        end else if (b == 8'hED) begin
          r = lead_byte(s, 2'd2, CONT_LOW, 8'h9F);
        end else if (b inside {[8'hE1:8'hEF]}) begin
          r = lead_byte(s, 2'd2, CONT_LOW, CONT_HIGH);
        end else if (b == 8'hF0) begin
          r = lead_byte(s, 2'd3, 8'h90, CONT_HIGH);
        end else if (b == 8'hF4) begin
          r = lead_byte(s, 2'd3, CONT_LOW, 8'h8F);
        end else if (b inside {[8'hF1:8'hF3]}) begin
          r = lead_byte(s, 2'd3, CONT_LOW, CONT_HIGH);
        end else begin
          r.utf8_error = 1'b1;
        end
      end else if (b < lo || b > hi) begin
        r.utf8_error = 1'b1;
      end else begin
        r.utf8_pending      = s.utf8_pending - 2'd1;
        r.utf8_expect_first = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic epv_state_t take_byte(epv_state_t s, logic [7:0] b);
    epv_state_t r;
    r = s;
    if (s.byte_count == '0 && b == CH_SLASH) begin
      r.leading_slash_seen = 1'b1;
    end
    if (s.byte_count != COUNT_CAP) begin
      r.byte_count = s.byte_count + COUNT_W'(1);
    end
    if (b == CH_BSLASH || b == CH_COLON || b <= 8'h1F || b inside {[8'h7F:8'h9F]}) begin
      r.forbidden_seen = 1'b1;
    end
    r.last_was_slash = (b == CH_SLASH);
    r = utf8_feed(r, b);
    if (b == CH_SLASH) begin
      r = close_segment(r);
    end else begin
      if (r.segment_length != 2'd3) begin
        r.segment_length = r.segment_length + 2'd1;
      end
      if (b != CH_DOT) begin
        r.segment_all_dots = 1'b0;
      end
    end
    return r;
  endfunction

  // Verdict in check order, from the state after the final segment close.
  function automatic epv_result_t verdict(epv_state_t s, logic [MAXLEN_W-1:0] max_len,
                                          logic [MAXDEP_W-1:0] max_dep);
    epv_result_t r;
    r.status        = ST_OK;
    r.reason        = RS_OK;
    r.segment_count = SEG_W'(s.depth_count);
    if (s.byte_count == '0) begin
      r.status = ST_UNSAFE; r.reason = RS_EMPTY;
    end else if (s.byte_count > COUNT_W'(max_len)) begin
      r.status = ST_LIMIT;  r.reason = RS_TOO_LONG;
    end else if (s.forbidden_seen) begin
      r.status = ST_UNSAFE; r.reason = RS_FORBIDDEN;
    end else if (s.leading_slash_seen) begin
      r.status = ST_UNSAFE; r.reason = RS_LEAD_SLASH;
    end else if (s.last_was_slash) begin
      r.status = ST_UNSAFE; r.reason = RS_TRAIL_SLASH;
    end else if (s.utf8_error || s.utf8_pending != 2'd0) begin
      r.status = ST_UNSAFE; r.reason = RS_BAD_UTF8;
    end else if (s.segment_error == SEGERR_DOT) begin
      r.status = ST_UNSAFE; r.reason = RS_DOT_SEGMENT;
    end else if (s.segment_error == SEGERR_EMPTY) begin
      r.status = ST_UNSAFE; r.reason = RS_EMPTY_SEGMENT;
    end else if (s.depth_count > DEPTH_W'(max_dep)) begin
      r.status = ST_LIMIT;  r.reason = RS_TOO_DEEP;
    end
    return r;
  endfunction

endpackage

[hdl/epv_path_state.sv]
// Running path state register, per-byte update and end-of-path verdict.
module epv_path_state (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [7:0]                     path_byte,
  input  logic                           has_byte,
  input  logic                           is_last,
  input  logic [epv_pkg::MAXLEN_W-1:0]   max_length,
  input  logic [epv_pkg::MAXDEP_W-1:0]   max_depth,
  output epv_pkg::epv_result_t           result
);
  import epv_pkg::*;

  `include "entry_path_validator_assert.svh"

  epv_state_t state;
  epv_state_t state_next;
  epv_state_t after_byte;
  epv_state_t after_close;

  always_comb begin
    after_byte  = has_byte ? take_byte(state, path_byte) : state;
    // close the open segment of a non-empty path
    after_close = (after_byte.byte_count != '0) ? close_segment(after_byte) : after_byte;
    result      = verdict(after_close, max_length, max_depth);
    state_next  = state;
    if (accept) begin
      state_next = is_last ? STATE_CLEAR : after_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `EPV_ASSERT_NEXT(a_clear_after_end, clk, rst, accept && is_last, state.byte_count == '0)
  `EPV_ASSERT_HOLDS(a_seg_error_code, clk, rst, state.segment_error != 2'd3)
  `EPV_ASSERT_HOLDS(a_depth_saturated, clk, rst, state.depth_count <= DEPTH_LIMIT)

endmodule

[hdl/epv_out_queue.sv]
// Two-entry result queue that decouples the verdict from the output handshake.
module epv_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  epv_pkg::epv_result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output epv_pkg::epv_result_t out_data
);
  import epv_pkg::*;

  `include "entry_path_validator_assert.svh"

  localparam logic [1:0] QUEUE_FULL = 2'd2;

  logic [1:0]  count;
  logic [1:0]  count_next;
  epv_result_t head;
  epv_result_t tail;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == QUEUE_FULL);
  assign out_data  = head;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // payload: advance tail to head on pop, land new result in first free slot
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == QUEUE_FULL) begin
        head <= tail;
      end else if (push) begin
        head <= push_data;
      end
      if (push && count == QUEUE_FULL) begin
        tail <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        tail <= push_data;
      end
    end
  end

  `EPV_ASSERT_HOLDS(a_count_range, clk, rst, count != 2'd3)
  `EPV_ASSERT_IMPLIES(a_no_push_when_full, clk, rst, push, count != QUEUE_FULL)
  `EPV_ASSERT_NEXT(a_drain_last, clk, rst, pop && !push && count == 2'd1, !out_valid)
  `EPV_ASSERT_NEXT(a_fill_empty, clk, rst, push && count == 2'd0, out_valid)

endmodule

[hdl/entry_path_validator.sv]
// Top level of the entry path validator: config registers, path state and result queue.
//
// Streams a relative path one byte per transfer and, on the transfer that
// carries is_last, produces one verdict (status, reason, segment_count).
// The block takes one input transfer every cycle while the result queue has room:
// each byte updates the running state (length, UTF-8 decoder, segment dot pattern,
// depth and the latched error flags) in a single short combinational step, and
// the verdict is registered into a two-entry result queue, appearing on the
// output in the cycle after the end-mark transfer at the earliest, later while
// older results still wait. in_ready drops only while both queue entries hold
// untaken results, so a single waiting result does not stall input.
// Transfers without a byte and without is_last are absorbed silently; a
// bare end mark on an empty path yields the empty verdict. Checks are taken
// in the order empty, too long, forbidden byte, leading slash, trailing
// slash, bad UTF-8, dot segment, empty segment, too deep. The two limit
// registers are written through cfg_we/cfg_index/cfg_data and must only be
// changed while the block is idle.
module entry_path_validator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [epv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [epv_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      path_byte,
  input  logic                            has_byte,
  input  logic                            is_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [3:0]                      reason,
  output logic [epv_pkg::SEG_W-1:0]       segment_count
);
  import epv_pkg::*;

  logic [MAXLEN_W-1:0] max_length;
  logic [MAXDEP_W-1:0] max_depth;
  logic                accept;
  logic                queue_full;
  epv_result_t         verdict_now;
  epv_result_t         head_result;

  // Limit registers: hold until written, mask data to register width.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
      max_depth  <= MAX_DEPTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_LENGTH: max_length <= cfg_data[MAXLEN_W-1:0];
        REG_MAX_DEPTH:  max_depth  <= cfg_data[MAXDEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a transfer whenever the result queue has room.
  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  epv_path_state u_state (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .path_byte  (path_byte),
    .has_byte   (has_byte),
    .is_last    (is_last),
    .max_length (max_length),
    .max_depth  (max_depth),
    .result     (verdict_now)
  );

  // Push the verdict only on the end-mark transfer.
  epv_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && is_last),
    .push_data (verdict_now),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head_result)
  );

  assign status        = head_result.status;
  assign reason        = head_result.reason;
  assign segment_count = head_result.segment_count;

endmodule

[tb/entry_path_validator_tb.sv]
// Self-checking testbench for the entry path validator: directed rows, random paths, saturation.
`timescale 1ns / 1ps

module entry_path_validator_tb;
  import epv_pkg::*;

  localparam int CYCLE_LIMIT   = 50_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int SUB_ITEMS     = 46;
  localparam int SUB_PHASES    = 9;
  localparam int SLASH_RUN     = 260;

  // One input transfer as it appears on the port.
  typedef struct packed {
    logic [7:0] b;
    logic       has;
    logic       last;
  } path_item_t;

  // Directed row: the transfer, and a typed-in verdict where it is obvious.
  typedef struct packed {
    path_item_t  item;
    logic        typed;
    epv_result_t want;
  } directed_row_t;

  // Mutation applied to an otherwise well-formed random path.
  typedef enum logic [3:0] {
    FLT_NONE, FLT_LEAD_SLASH, FLT_TRAIL_SLASH, FLT_EMPTY_SEG, FLT_DOT_SEG,
    FLT_FORBIDDEN, FLT_BAD_LEAD, FLT_BAD_CONT, FLT_TRUNCATED, FLT_NOISE
  } path_fault_t;

  // Running scan state of the path currently being received.
  typedef struct {
    logic [COUNT_W-1:0] len_seen;
    logic               ends_slash;
    logic               bad_char;
    logic               starts_slash;
    logic               enc_bad;
    logic [1:0]         enc_left;
    logic               enc_first;
    logic [7:0]         enc_lo;
    logic [7:0]         enc_hi;
    logic [1:0]         seg_len;
    logic               seg_dots;
    logic [1:0]         seg_fault;
    logic [DEPTH_W-1:0] seg_total;
  } path_track_t;

  localparam epv_result_t NO_VERDICT = '0;
  localparam int DIRECTED_ROWS = 25;

  // Walk the verdict order: empty, each forbidden class, leading and trailing
  // slash, bad and truncated UTF-8, dot and empty segments, a bare end mark
  // after bytes, an ignored transfer mid-path and a legal "..." segment.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{ST_UNSAFE, RS_EMPTY, 9'd0}},
    '{'{8'h61, 1'b1, 1'b1}, 1'b1, '{ST_OK, RS_OK, 9'd1}},
    '{'{8'h00, 1'b1, 1'b1}, 1'b1, '{ST_UNSAFE, RS_FORBIDDEN, 9'd1}},
    '{'{8'hFF, 1'b1, 1'b1}, 1'b1, '{ST_UNSAFE, RS_BAD_UTF8, 9'd1}},
    '{'{8'h2F, 1'b1, 1'b1}, 1'b1, '{ST_UNSAFE, RS_LEAD_SLASH, 9'd2}},
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{8'h2F, 1'b1, 1'b1}, 1'b1, '{ST_UNSAFE, RS_TRAIL_SLASH, 9'd2}},
    '{'{8'h2E, 1'b1, 1'b1}, 1'b1, '{ST_UNSAFE, RS_DOT_SEGMENT, 9'd1}},
    '{'{8'h2E, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{8'h2E, 1'b1, 1'b1}, 1'b1, '{ST_UNSAFE, RS_DOT_SEGMENT, 9'd1}},
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b0, NO_VERDICT},
    '{'{8'h2F, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{8'h2F, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{8'h62, 1'b1, 1'b1}, 1'b1, '{ST_UNSAFE, RS_EMPTY_SEGMENT, 9'd3}},
    '{'{8'hC3, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{8'hA9, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{8'h00, 1'b0, 1'b1}, 1'b0, NO_VERDICT},
    '{'{8'h5C, 1'b1, 1'b1}, 1'b1, '{ST_UNSAFE, RS_FORBIDDEN, 9'd1}},
    '{'{8'h3A, 1'b1, 1'b1}, 1'b1, '{ST_UNSAFE, RS_FORBIDDEN, 9'd1}},
    '{'{8'h9F, 1'b1, 1'b1}, 1'b1, '{ST_UNSAFE, RS_FORBIDDEN, 9'd1}},
    '{'{8'hE2, 1'b1, 1'b1}, 1'b1, '{ST_UNSAFE, RS_BAD_UTF8, 9'd1}},
    '{'{8'h2E, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{8'h2E, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{8'h2E, 1'b1, 1'b1}, 1'b0, NO_VERDICT}
  };

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [7:0]           path_byte = '0;
  logic                 has_byte  = 1'b0;
  logic                 is_last   = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic [3:0]           reason;
  logic [SEG_W-1:0]     segment_count;

  // Predictor copy of the limit registers and of the path scan.
  logic [MAXLEN_W-1:0] lim_length = MAX_LENGTH_RESET;
  logic [MAXDEP_W-1:0] lim_depth  = MAX_DEPTH_RESET;
  path_track_t         trk;

  epv_result_t verdicts_due [$];
  path_item_t  path_buf [$];

  int send_idle_pct = 17;
  int recv_idle_pct = 47;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int fault_count   = 0;
  int transfers     = 0;
  int verdicts_seen = 0;
  int settings_used = 1;
  int cycles        = 0;
  int reason_hits [16];

  entry_path_validator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .path_byte     (path_byte),
    .has_byte      (has_byte),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .reason        (reason),
    .segment_count (segment_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_track();
    trk.len_seen     = '0;
    trk.ends_slash   = 1'b0;
    trk.bad_char     = 1'b0;
    trk.starts_slash = 1'b0;
    trk.enc_bad      = 1'b0;
    trk.enc_left     = 2'd0;
    trk.enc_first    = 1'b0;
    trk.enc_lo       = 8'h80;
    trk.enc_hi       = 8'hBF;
    trk.seg_len      = 2'd0;
    trk.seg_dots     = 1'b1;
    trk.seg_fault    = SEGERR_NONE;
    trk.seg_total    = '0;
  endfunction

  // Close the open segment: latch only the first bad one, count depth up to saturation.
  function automatic void end_segment();
    if (trk.seg_fault == SEGERR_NONE) begin
      if (trk.seg_len == 2'd0) begin
        trk.seg_fault = SEGERR_EMPTY;
      end else if (trk.seg_dots && trk.seg_len < 2'd3) begin
        trk.seg_fault = SEGERR_DOT;
      end
    end
    if (trk.seg_total != DEPTH_LIMIT) begin
      trk.seg_total = trk.seg_total + 1'b1;
    end
    trk.seg_len  = 2'd0;
    trk.seg_dots = 1'b1;
  endfunction

  // UTF-8 well-formedness: a lead byte sets how many continuations follow and
  // the window for the first one (overlong, surrogate and > U+10FFFF cut-offs).
  function automatic void decode_utf8(logic [7:0] b);
    logic [1:0] need;
    logic [7:0] lo;
    logic [7:0] hi;
    need = 2'd0;
    lo   = 8'h80;
    hi   = 8'hBF;
    if (trk.enc_bad) begin
      return;
    end
    if (trk.enc_left == 2'd0) begin
      if (b < 8'h80) begin
        return;
      end
      if (b >= 8'hC2 && b <= 8'hDF) begin
        need = 2'd1;
      end else if (b == 8'hE0) begin
        need = 2'd2;
        lo   = 8'hA0;
      end else if (b == 8'hED) begin
        need = 2'd2;
        hi   = 8'h9F;
      end else if (b >= 8'hE1 && b <= 8'hEF) begin
        need = 2'd2;
      end else if (b == 8'hF0) begin
        need = 2'd3;
        lo   = 8'h90;
      end else if (b == 8'hF4) begin
        need = 2'd3;
        hi   = 8'h8F;
      end else if (b >= 8'hF1 && b <= 8'hF3) begin
        need = 2'd3;
      end
      if (need == 2'd0) begin
        trk.enc_bad = 1'b1;
      end else begin
        trk.enc_left  = need;
        trk.enc_first = 1'b1;
        trk.enc_lo    = lo;
        trk.enc_hi    = hi;
      end
    end else begin
      if (trk.enc_first) begin
        lo = trk.enc_lo;
        hi = trk.enc_hi;
      end
      if (b < lo || b > hi) begin
        trk.enc_bad = 1'b1;
      end else begin
        trk.enc_left  = trk.enc_left - 2'd1;
        trk.enc_first = 1'b0;
      end
    end
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    if (trk.len_seen == '0 && b == CH_SLASH) begin
      trk.starts_slash = 1'b1;
    end
    if (trk.len_seen != {COUNT_W{1'b1}}) begin
      trk.len_seen = trk.len_seen + 1'b1;
    end
    if (b == CH_BSLASH || b == CH_COLON || b <= 8'h1F || (b >= 8'h7F && b <= 8'h9F)) begin
      trk.bad_char = 1'b1;
    end
    trk.ends_slash = (b == CH_SLASH);
    decode_utf8(b);
    if (b == CH_SLASH) begin
      end_segment();
    end else begin
      if (trk.seg_len != 2'd3) begin
        trk.seg_len = trk.seg_len + 2'd1;
      end
      if (b != CH_DOT) begin
        trk.seg_dots = 1'b0;
      end
    end
  endfunction

  // Verdict at the end mark, first failing check wins; then start a fresh path.
  function automatic epv_result_t judge_path();
    epv_result_t r;
    if (trk.len_seen != '0) begin
      end_segment();
    end
    r.status        = ST_OK;
    r.reason        = RS_OK;
    r.segment_count = SEG_W'(trk.seg_total);
    if (trk.len_seen == '0) begin
      r.status = ST_UNSAFE; r.reason = RS_EMPTY;
    end else if (trk.len_seen > COUNT_W'(lim_length)) begin
      r.status = ST_LIMIT;  r.reason = RS_TOO_LONG;
    end else if (trk.bad_char) begin
      r.status = ST_UNSAFE; r.reason = RS_FORBIDDEN;
    end else if (trk.starts_slash) begin
      r.status = ST_UNSAFE; r.reason = RS_LEAD_SLASH;
    end else if (trk.ends_slash) begin
      r.status = ST_UNSAFE; r.reason = RS_TRAIL_SLASH;
    end else if (trk.enc_bad || trk.enc_left != 2'd0) begin
      r.status = ST_UNSAFE; r.reason = RS_BAD_UTF8;
    end else if (trk.seg_fault == SEGERR_DOT) begin
      r.status = ST_UNSAFE; r.reason = RS_DOT_SEGMENT;
    end else if (trk.seg_fault == SEGERR_EMPTY) begin
      r.status = ST_UNSAFE; r.reason = RS_EMPTY_SEGMENT;
    end else if (trk.seg_total > DEPTH_W'(lim_depth)) begin
      r.status = ST_LIMIT;  r.reason = RS_TOO_DEEP;
    end
    clear_track();
    return r;
  endfunction

  // Advance the predictor by one accepted transfer; queue its verdict if any.
  function automatic void apply_item(path_item_t it, logic typed, epv_result_t want);
    epv_result_t got;
    if (it.has) begin
      scan_byte(it.b);
    end
    if (it.last) begin
      got = judge_path();
      verdicts_due = {verdicts_due, (typed ? want : got)};
    end
  endfunction

  // ------------------------------------------------------------ path builder

  // Queue a byte, now and then preceded by a transfer that carries nothing.
  function automatic void add_byte(logic [7:0] b);
    if ($urandom_range(19) == 0) begin
      path_buf = {path_buf, path_item_t'{8'($urandom), 1'b0, 1'b0}};
    end
    path_buf = {path_buf, path_item_t'{b, 1'b1, 1'b0}};
  endfunction

  // Continuation byte that is not forbidden and fits every first window but those of ED and F4.
  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'hA0, 8'hBF));
  endfunction

  function automatic void add_utf8();
    logic [7:0] lead;
    case ($urandom_range(5))
      0: begin
        add_byte(8'($urandom_range(8'hC2, 8'hDF)));
        add_byte(cont_byte());
      end
      1: begin
        add_byte(8'hE0);
        add_byte(cont_byte());
        add_byte(cont_byte());
      end
      2: begin
        lead = 8'($urandom_range(8'hE1, 8'hEF));
        add_byte(lead == 8'hED ? 8'hEE : lead);
        add_byte(cont_byte());
        add_byte(cont_byte());
      end
      3: begin
        add_byte(8'hF0);
        repeat (3) add_byte(cont_byte());
      end
      4: begin
        add_byte(8'($urandom_range(8'hF1, 8'hF3)));
        repeat (3) add_byte(cont_byte());
      end
      default: begin
        // Legal ED and F4 sequences need low continuations, which are forbidden bytes.
        if ($urandom_range(1) == 0) begin
          add_byte(8'hED);
          add_byte(8'($urandom_range(8'h80, 8'h9F)));
          add_byte(cont_byte());
        end else begin
          add_byte(8'hF4);
          add_byte(8'($urandom_range(8'h80, 8'h8F)));
          add_byte(cont_byte());
          add_byte(cont_byte());
        end
      end
    endcase
  endfunction

  function automatic void add_segment();
    int unsigned pick;
    logic [7:0]  c;
    repeat ($urandom_range(1, 5)) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        add_byte(CH_DOT);
      end else if (pick < 85) begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == CH_SLASH || c == CH_BSLASH || c == CH_COLON) begin
          c = 8'h5F;
        end
        add_byte(c);
      end else begin
        add_utf8();
      end
    end
  endfunction

  function automatic void add_fault_bytes(path_fault_t fault);
    case (fault)
      FLT_FORBIDDEN: begin
        case ($urandom_range(3))
          0:       add_byte(8'($urandom_range(8'h00, 8'h1F)));
          1:       add_byte(CH_BSLASH);
          2:       add_byte(CH_COLON);
          default: add_byte(8'($urandom_range(8'h7F, 8'h9F)));
        endcase
      end
      FLT_BAD_LEAD: begin
        case ($urandom_range(2))
          0:       add_byte(8'($urandom_range(8'hC0, 8'hC1)));
          1:       add_byte(8'($urandom_range(8'hF5, 8'hFF)));
          default: add_byte(cont_byte());
        endcase
      end
      FLT_BAD_CONT: begin
        case ($urandom_range(3))
          0: begin
            add_byte(8'($urandom_range(8'hC2, 8'hDF)));
            add_byte(8'h41);
          end
          1: begin
            add_byte(8'hED);
            add_byte(cont_byte());
          end
          2: begin
            add_byte(8'hF4);
            add_byte(cont_byte());
          end
          default: begin
            add_byte(8'hE0);
            add_byte(8'h78);
          end
        endcase
      end
      FLT_NOISE: begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      end
      default: begin
      end
    endcase
  endfunction

  // Build one random path in path_buf: mostly well-formed segments with random
  // content and at most one mutation; a few raw noise paths and empty paths.
  function automatic void build_path();
    int unsigned kind;
    int unsigned nseg;
    int unsigned where;
    int unsigned s;
    path_fault_t fault;
    path_buf.delete();
    kind = $urandom_range(99);
    if (kind < 3) begin
      path_buf = {path_buf, path_item_t'{8'($urandom), 1'b0, 1'b1}};
      return;
    end
    if (kind < 12) begin
      repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
    end else begin
      nseg  = ($urandom_range(7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      fault = FLT_NONE;
      if ($urandom_range(99) < 45) begin
        fault = path_fault_t'($urandom_range(FLT_LEAD_SLASH, FLT_NOISE));
      end
      if (fault == FLT_EMPTY_SEG && nseg < 2) begin
        nseg = 2;
      end
      where = (fault == FLT_EMPTY_SEG) ? $urandom_range(1, nseg - 1) : $urandom_range(nseg - 1);
      if (fault == FLT_LEAD_SLASH) begin
        add_byte(CH_SLASH);
      end
      for (s = 0; s < nseg; s++) begin
        if (s != 0) begin
          add_byte(CH_SLASH);
          if (fault == FLT_EMPTY_SEG && s == where) begin
            add_byte(CH_SLASH);
          end
        end
        if (fault == FLT_DOT_SEG && s == where) begin
          repeat ($urandom_range(1, 2)) add_byte(CH_DOT);
        end else begin
          add_segment();
        end
        if (s == where) begin
          add_fault_bytes(fault);
        end
      end
      if (fault == FLT_TRAIL_SLASH) begin
        add_byte(CH_SLASH);
      end else if (fault == FLT_TRUNCATED) begin
        case ($urandom_range(2))
          0: add_byte(8'($urandom_range(8'hC2, 8'hDF)));
          1: begin
            add_byte(8'hE1);
            add_byte(cont_byte());
          end
          default: begin
            add_byte(8'hF1);
            add_byte(cont_byte());
            add_byte(cont_byte());
          end
        endcase
      end
    end
    // Close with a bare end mark now and then, otherwise on the final byte.
    if ($urandom_range(4) == 0) begin
      path_buf = {path_buf, path_item_t'{8'($urandom), 1'b0, 1'b1}};
    end else begin
      path_buf[path_buf.size() - 1].last = 1'b1;
    end
  endfunction

  // ------------------------------------------------------------------ drivers

  // Offer one transfer, hold it until accepted, then advance the predictor.
  task automatic send_item(input path_item_t it, input logic typed, input epv_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    path_byte <= it.b;
    has_byte  <= it.has;
    is_last   <= it.last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    transfers++;
    apply_item(it, typed, want);
  endtask

  // Path made of slashes only, long enough to drive the segment count to saturation.
  task automatic send_slashes(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      send_item(path_item_t'{CH_SLASH, 1'b1, k == n - 1}, 1'b0, NO_VERDICT);
    end
  endtask

  // Drop valid, wait for every verdict, then give the block time to go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_MAX_LENGTH) begin
      lim_length = val[MAXLEN_W-1:0];
    end else begin
      lim_depth = val[MAXDEP_W-1:0];
    end
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] len_val, input logic [CFG_W-1:0] dep_val);
    write_reg(REG_MAX_LENGTH, len_val);
    write_reg(REG_MAX_DEPTH, dep_val);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ------------------------------------------------------------------ checker

  function automatic void compare_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin
    epv_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict with none expected, expected nothing, got %0d/%0d/%0d",
                 $time, status, reason, segment_count);
        fault_count++;
      end else begin
        want = verdicts_due.pop_front();
        compare_field("status", want.status, status);
        compare_field("reason", want.reason, reason);
        compare_field("segment_count", want.segment_count, segment_count);
        reason_hits[reason]++;
        verdicts_seen++;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("entry_path_validator verification failed");
    $finish;
  end

  // --------------------------------------------------------------- main flow

  initial begin
    int r;
    int sub;
    int budget;
    clear_track();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed rows run on the reset limits, with sender and receiver both idling.
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // Random paths in three idling regimes, three limit settings in each.
    for (sub = 0; sub < SUB_PHASES; sub++) begin
      drain();
      case (sub / 3)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (sub)
        0:       set_limits(16'd1, 16'd1);
        1:       set_limits(16'd24, 16'd3);
        2:       set_limits(16'hFFFF, 16'h00FF);
        3:       set_limits(16'd12, 16'hAB04);
        4:       set_limits(16'd4096, 16'd32);
        5:       set_limits(16'($urandom_range(8, 40)), 16'($urandom_range(1, 6)));
        6:       set_limits(16'd40, 16'd2);
        7:       set_limits(16'hFFFF, 16'hFF01);
        default: set_limits(16'($urandom_range(3, 64)),
                            {8'($urandom), 8'($urandom_range(1, 10))});
      endcase
      // Hold the output off for a long stretch so the result queue fills and
      // the input stalls while paths keep coming.
      if (sub == 1 || sub == 7) begin
        hold_reqs++;
      end
      budget = 0;
      while (budget < SUB_ITEMS) begin
        build_path();
        foreach (path_buf[i]) begin
          send_item(path_buf[i], 1'b0, NO_VERDICT);
          if (path_buf[i].has || path_buf[i].last) begin
            budget++;
          end
        end
      end
    end

    // Saturation: more segments than the segment counter can count.
    drain();
    set_limits(16'hFFFF, 16'h00FF);
    send_slashes(SLASH_RUN);

    drain();
    $display("Run covered %0d transfers, %0d verdicts checked, %0d limit settings.",
             transfers, verdicts_seen, settings_used);
    $write("Reasons: ok %0d empty %0d long %0d forbid %0d lead %0d trail %0d",
           reason_hits[RS_OK], reason_hits[RS_EMPTY], reason_hits[RS_TOO_LONG],
           reason_hits[RS_FORBIDDEN], reason_hits[RS_LEAD_SLASH],
           reason_hits[RS_TRAIL_SLASH]);
    $display(" utf8 %0d dot %0d emptyseg %0d deep %0d",
             reason_hits[RS_BAD_UTF8], reason_hits[RS_DOT_SEGMENT],
             reason_hits[RS_EMPTY_SEGMENT], reason_hits[RS_TOO_DEEP]);
    if (fault_count == 0) begin
      $display("entry_path_validator verification clean");
    end else begin
      $display("entry_path_validator verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/epv_pkg.sv
hdl/epv_path_state.sv
hdl/epv_out_queue.sv
hdl/entry_path_validator.sv
tb/entry_path_validator_tb.sv
